>>> hw/rtl/rpn_stack_calculator_macros.svh
// Assertion macros used by the verification checker of the RPN calculator.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RPN_STACK_CALCULATOR_MACROS_SVH
`define RPN_STACK_CALCULATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RPN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rpn_pkg.sv
// Shared types and constants of the RPN stack calculator.
// Used by rpn_alu, rpn_stack_calculator and rpn_checker; depends on nothing.
package rpn_pkg;

    localparam int WORD_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int DEPTH_OUT_W = 5;
    localparam int ITER_STEPS  = 32;
    localparam int ITER_CNT_W  = $clog2(ITER_STEPS);

    localparam logic [WORD_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] S32_MIN = 32'h8000_0000;

    // Operation codes of the token beat. Codes six and seven are invalid.
    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_SUB    = 3'd2;
    localparam logic [2:0] OP_MUL    = 3'd3;
    localparam logic [2:0] OP_DIV    = 3'd4;
    localparam logic [2:0] OP_FINISH = 3'd5;

    // Status codes of the result beat.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_BADOP = 3'd3;
    localparam logic [2:0] ST_DIVZ  = 3'd4;

    typedef struct packed {
        logic [2:0]               op;
        logic signed [WORD_W-1:0] operand;
    } token_t;

    typedef struct packed {
        logic [2:0]                status;
        logic signed [WORD_W-1:0]  value;
        logic [DEPTH_OUT_W-1:0]    depth_now;
    } result_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic              start;
        alu_op_t           kind;
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
    } alu_cmd_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } alu_rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_EXEC,
        S_RESP
    } ctrl_state_t;

    typedef enum logic [2:0] {
        A_IDLE,
        A_ADD,
        A_SETUP,
        A_ITER,
        A_FIX
    } alu_state_t;

endpackage

>>> hw/rtl/rpn_alu.sv
// Iterative Q16.16 arithmetic unit: add, subtract, shift-add multiply and
// restoring divide, all on one shared 34-bit adder. Depends on rpn_pkg.
module rpn_alu
    import rpn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_cmd_t cmd,
    output alu_rsp_t rsp
);

    alu_state_t state_reg, state_next;
    alu_op_t    kind_reg, kind_next;

    logic [WORD_W-1:0]     left_reg, left_next;
    logic [WORD_W-1:0]     right_reg, right_next;
    logic [WORD_W-1:0]     mag_a_reg, mag_a_next;
    logic [WORD_W-1:0]     mag_b_reg, mag_b_next;
    logic                  neg_reg, neg_next;
    logic                  sat_reg, sat_next;
    logic [WORD_W:0]       hi_reg, hi_next;
    logic [WORD_W-1:0]     lo_reg, lo_next;
    logic [ITER_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0]     result_reg, result_next;
    logic                  done_reg, done_next;

    logic [WORD_W+1:0] add_a, add_b, add_sum;
    logic              add_sub;

    logic                  div_big;
    logic [WORD_W:0]       div_shift;
    logic                  div_ge;
    logic [WORD_W:0]       mul_sel;
    logic [2*WORD_W-1:0]   prod_mag, prod_s;
    logic [2*WORD_W-FRAC_W-1:0] prod_sh;

    // The one adder every operation shares.
    assign add_sum = add_a + (add_b ^ {(WORD_W+2){add_sub}}) + (WORD_W+2)'(add_sub);

    // When the quotient needs more than 32 bits it saturates without iterating.
    assign div_big   = {16'd0, mag_a_reg} >= {mag_b_reg, 16'd0};
    assign div_shift = {hi_reg[WORD_W-1:0], lo_reg[WORD_W-1]};
    assign div_ge    = !add_sum[WORD_W+1];
    assign mul_sel   = lo_reg[0] ? add_sum[WORD_W:0] : hi_reg;
    assign prod_mag  = {hi_reg[WORD_W-1:0], lo_reg};
    assign prod_s    = neg_reg ? (~prod_mag + 64'd1) : prod_mag;
    assign prod_sh   = prod_s[2*WORD_W-1:FRAC_W];

    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (state_reg)
            A_ADD:
            begin
                add_a   = {{2{left_reg[WORD_W-1]}}, left_reg};
                add_b   = {{2{right_reg[WORD_W-1]}}, right_reg};
                add_sub = (kind_reg == ALU_SUB);
            end
            A_ITER:
            begin
                if (kind_reg == ALU_MUL)
                begin
                    add_a = {1'b0, hi_reg};
                    add_b = {2'b00, mag_a_reg};
                end
                else
                begin
                    add_a   = {1'b0, div_shift};
                    add_b   = {2'b00, mag_b_reg};
                    add_sub = 1'b1;
                end
            end
            default:
            begin
                add_a = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ((cmd.kind == ALU_MUL) || (cmd.kind == ALU_DIV)) ?
                                 A_SETUP : A_ADD;
                end
            end
            A_ADD:
            begin
                state_next = A_IDLE;
            end
            A_SETUP:
            begin
                state_next = ((kind_reg == ALU_DIV) && div_big) ? A_FIX : A_ITER;
            end
            A_ITER:
            begin
                if (cnt_reg == ITER_CNT_W'(ITER_STEPS - 1))
                begin
                    state_next = A_FIX;
                end
            end
            A_FIX:
            begin
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_comb
    begin
        kind_next   = kind_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        mag_a_next  = mag_a_reg;
        mag_b_next  = mag_b_reg;
        neg_next    = neg_reg;
        sat_next    = sat_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        case (state_reg)
            A_IDLE:
            begin
                if (cmd.start)
                begin
                    kind_next  = cmd.kind;
                    left_next  = cmd.left;
                    right_next = cmd.right;
                    mag_a_next = cmd.left[WORD_W-1] ? (~cmd.left + 32'd1) : cmd.left;
                    mag_b_next = cmd.right[WORD_W-1] ? (~cmd.right + 32'd1) : cmd.right;
                    neg_next   = cmd.left[WORD_W-1] ^ cmd.right[WORD_W-1];
                end
            end
            A_ADD:
            begin
                if (add_sum[WORD_W] != add_sum[WORD_W-1])
                begin
                    result_next = add_sum[WORD_W] ? S32_MIN : S32_MAX;
                end
                else
                begin
                    result_next = add_sum[WORD_W-1:0];
                end
                done_next = 1'b1;
            end
            A_SETUP:
            begin
                cnt_next = '0;
                sat_next = 1'b0;
                if (kind_reg == ALU_MUL)
                begin
                    hi_next = '0;
                    lo_next = mag_b_reg;
                end
                else if (div_big)
                begin
                    sat_next = 1'b1;
                end
                else
                begin
                    // Dividend is |left| << 16; its top 16 bits seed the remainder.
                    hi_next = {17'd0, mag_a_reg[WORD_W-1:FRAC_W]};
                    lo_next = {mag_a_reg[FRAC_W-1:0], 16'd0};
                end
            end
            A_ITER:
            begin
                cnt_next = cnt_reg + ITER_CNT_W'(1);
                if (kind_reg == ALU_MUL)
                begin
                    hi_next = {1'b0, mul_sel[WORD_W:1]};
                    lo_next = {mul_sel[0], lo_reg[WORD_W-1:1]};
                end
                else
                begin
                    hi_next = {1'b0, div_ge ? add_sum[WORD_W-1:0] : div_shift[WORD_W-1:0]};
                    lo_next = {lo_reg[WORD_W-2:0], div_ge};
                end
            end
            A_FIX:
            begin
                done_next = 1'b1;
                if (kind_reg == ALU_MUL)
                begin
                    // Arithmetic shift of the signed product floors toward minus infinity.
                    if (!prod_sh[47] && (|prod_sh[46:31]))
                    begin
                        result_next = S32_MAX;
                    end
                    else if (prod_sh[47] && !(&prod_sh[46:31]))
                    begin
                        result_next = S32_MIN;
                    end
                    else
                    begin
                        result_next = prod_sh[WORD_W-1:0];
                    end
                end
                else if (sat_reg)
                begin
                    result_next = neg_reg ? S32_MIN : S32_MAX;
                end
                else if (!neg_reg)
                begin
                    result_next = lo_reg[WORD_W-1] ? S32_MAX : lo_reg;
                end
                else
                begin
                    result_next = (lo_reg[WORD_W-1] && (|lo_reg[WORD_W-2:0])) ?
                                  S32_MIN : (~lo_reg + 32'd1);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        mag_a_reg  <= mag_a_next;
        mag_b_reg  <= mag_b_next;
        neg_reg    <= neg_next;
        sat_reg    <= sat_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

>>> hw/rtl/rpn_stack_calculator.sv
// Top level of the RPN stack calculator: sequencer, operand stack and output register.
// Depends on rpn_pkg and rpn_alu.
//
// Evaluates reverse Polish expressions over signed Q16.16 values, one token beat at
// a time, with one result beat per token. The top of stack lives in a register and
// the rest in a single-port-write, registered-read memory of STACK_DEPTH-1 useful
// entries. Push, finish, invalid codes and stack errors go from acceptance straight to
// the response state, and a divide by zero is caught in the load state; add and
// subtract make one pass through rpn_alu, while multiply and divide run 32 iterations
// of its shared adder (a divide whose quotient saturates skips them). token_ready
// is low from acceptance until the result has moved into the output register, which
// holds it until it is taken. Errors leave the stack as it was.
module rpn_stack_calculator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    token_valid,
    output logic    token_ready,
    input  token_t  token,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    ctrl_state_t state_reg, state_next;

    logic [DW-1:0]     depth_reg, depth_next;
    logic [WORD_W-1:0] top_reg, top_next;
    alu_op_t           kind_reg, kind_next;
    result_t           res_reg, res_next;
    result_t           out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] rd_data_reg;

    logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     rd_addr;

    logic              accept;
    logic              out_load;
    logic [WORD_W-1:0] top_view;
    logic              full;
    alu_cmd_t          alu_cmd;
    alu_rsp_t          alu_rsp;

    assign accept    = token_valid && token_ready;
    assign out_load  = (state_reg == S_RESP) && (!out_valid_reg || result_ready);
    assign top_view  = (depth_reg == '0) ? '0 : top_reg;
    assign full      = (depth_reg == DW'(STACK_DEPTH));
    // The left operand sits just below the top-of-stack register.
    assign rd_addr   = AW'(depth_reg - DW'(2));
    assign mem_waddr = AW'(depth_reg - DW'(1));

    assign token_ready  = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    rpn_alu u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (alu_cmd),
        .rsp   (alu_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((token.op == OP_ADD || token.op == OP_SUB || token.op == OP_MUL ||
                         token.op == OP_DIV) && (depth_reg >= DW'(2)))
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_LOAD:
            begin
                state_next = ((kind_reg == ALU_DIV) && (top_reg == '0)) ? S_RESP : S_EXEC;
            end
            S_EXEC:
            begin
                if (alu_rsp.done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        depth_next     = depth_reg;
        top_next       = top_reg;
        kind_next      = kind_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        alu_cmd.start  = 1'b0;
        alu_cmd.kind   = kind_reg;
        alu_cmd.left   = rd_data_reg;
        alu_cmd.right  = top_reg;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next.status    = ST_OK;
                    res_next.value     = top_view;
                    res_next.depth_now = DEPTH_OUT_W'(depth_reg);
                    case (token.op)
                        OP_PUSH:
                        begin
                            if (full)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                mem_we             = (depth_reg != '0);
                                top_next           = token.operand;
                                depth_next         = depth_reg + DW'(1);
                                res_next.value     = token.operand;
                                res_next.depth_now = DEPTH_OUT_W'(depth_reg + DW'(1));
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                        begin
                            if (depth_reg < DW'(2))
                            begin
                                res_next.status = ST_UNDER;
                            end
                            case (token.op)
                                OP_ADD:  kind_next = ALU_ADD;
                                OP_SUB:  kind_next = ALU_SUB;
                                OP_MUL:  kind_next = ALU_MUL;
                                default: kind_next = ALU_DIV;
                            endcase
                        end
                        OP_FINISH:
                        begin
                            if (depth_reg == '0)
                            begin
                                res_next.status = ST_UNDER;
                            end
                            else
                            begin
                                depth_next         = '0;
                                res_next.value     = top_reg;
                                res_next.depth_now = '0;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_BADOP;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                if ((kind_reg == ALU_DIV) && (top_reg == '0))
                begin
                    res_next.status = ST_DIVZ;
                end
                else
                begin
                    alu_cmd.start = 1'b1;
                end
            end
            S_EXEC:
            begin
                if (alu_rsp.done)
                begin
                    top_next           = alu_rsp.result;
                    depth_next         = depth_reg - DW'(1);
                    res_next.status    = ST_OK;
                    res_next.value     = alu_rsp.result;
                    res_next.depth_now = DEPTH_OUT_W'(depth_reg - DW'(1));
                end
            end
            S_RESP:
            begin
                if (out_load)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        kind_reg <= kind_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // On a push the old top moves down into the memory.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= top_reg;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

endmodule

>>> hw/rtl/rpn_checker.sv
// Port-level checker for the RPN stack calculator, bound to the top level.
// Depends on rpn_pkg and rpn_stack_calculator_macros.svh.
`include "rpn_stack_calculator_macros.svh"

module rpn_checker
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input logic    clk,
    input logic    rst_n,
    input logic    token_valid,
    input logic    token_ready,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    localparam logic [DEPTH_OUT_W-1:0] FULL_DEPTH = DEPTH_OUT_W'(STACK_DEPTH);

    logic token_beat;
    logic stall_beat;
    logic full_beat;
    logic under_beat;
    assign token_beat = token_valid && token_ready;
    assign stall_beat = result_valid && !result_ready;
    assign full_beat  = result_valid && (result.status == ST_FULL);
    assign under_beat = result_valid && (result.status == ST_UNDER);

    // A stalled result beat holds its value.
    `RPN_ASSERT_NEXT(a_result_hold, stall_beat, result_valid && $stable(result), "result not held")

    // The block works on one token at a time.
    `RPN_ASSERT_NEXT(a_busy_after_token, token_beat, !token_ready, "token accepted while busy")

    // A full-stack push reports the full depth.
    `RPN_ASSERT_NOW(a_full_depth, full_beat, result.depth_now == FULL_DEPTH, "full at wrong depth")

    // Underflow happens only with fewer than two entries.
    `RPN_ASSERT_NOW(a_under_depth, under_beat, result.depth_now <= DEPTH_OUT_W'(1), "bad underflow")

endmodule

bind rpn_stack_calculator rpn_checker #(.STACK_DEPTH(STACK_DEPTH)) u_rpn_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

>>> tb/sv/rpn_stack_calculator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of rpn_stack_calculator: directed corner tokens, then random
// expressions under random idling on both sides. Depends on rpn_pkg and the RTL only.
module rpn_stack_calculator_test;
    import rpn_pkg::*;

    localparam int CALC_DEPTH   = 16;
    localparam int ITEM_TOTAL   = 1120;
    localparam int QUIET_ITEMS  = 150;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int REPORT_CAP   = 100;

    localparam logic [2:0] OP_BAD_LO = 3'd6;
    localparam logic [2:0] OP_BAD_HI = 3'd7;

    // Tracks the operand stack and queues the result beat each token must produce.
    class calc_scoreboard;
        logic [WORD_W-1:0] words[CALC_DEPTH];
        int unsigned       depth;
        result_t           expected_q[$];
        int unsigned       errors;

        function logic [WORD_W-1:0] clamp_word(longint v);
            if (v > 64'sd2147483647)
                return S32_MAX;
            if (v < -64'sd2147483648)
                return S32_MIN;
            return v[WORD_W-1:0];
        endfunction

        function logic [WORD_W-1:0] top_word();
            return (depth == 0) ? '0 : words[depth-1];
        endfunction

        function void note_token(token_t t);
            result_t           r;
            int                lhs;
            int                rhs;
            logic [WORD_W-1:0] res;
            bit                popped;
            r = '0;
            r.status = ST_OK;
            res = '0;
            popped = 1'b0;
            case (t.op)
                OP_PUSH:
                    if (depth >= CALC_DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        words[depth] = t.operand;
                        depth++;
                    end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                    if (depth < 2)
                        r.status = ST_UNDER;
                    else
                    begin
                        rhs = words[depth-1];
                        lhs = words[depth-2];
                        case (t.op)
                            OP_ADD: res = clamp_word(longint'(lhs) + longint'(rhs));
                            OP_SUB: res = clamp_word(longint'(lhs) - longint'(rhs));
                            // The arithmetic shift floors the product.
                            OP_MUL: res = clamp_word((longint'(lhs) * longint'(rhs)) >>> FRAC_W);
                            default:
                                if (rhs == 0)
                                    r.status = ST_DIVZ;
                                else
                                    res = clamp_word((longint'(lhs) <<< FRAC_W) / longint'(rhs));
                        endcase
                        if (r.status == ST_OK)
                        begin
                            depth--;
                            words[depth-1] = res;
                        end
                    end
                OP_FINISH:
                    if (depth == 0)
                        r.status = ST_UNDER;
                    else
                    begin
                        res = words[depth-1];
                        depth = 0;
                        popped = 1'b1;
                    end
                default:
                    r.status = ST_BADOP;
            endcase
            r.value = popped ? res : top_word();
            r.depth_now = DEPTH_OUT_W'(depth);
            expected_q.push_back(r);
        endfunction

        function void flag(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            errors++;
            if (errors <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: result beat with nothing expected, expected none, got %p",
                             $time, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                flag("status", want.status, got.status);
            if (got.value !== want.value)
                flag("value", want.value, got.value);
            if (got.depth_now !== want.depth_now)
                flag("depth_now", want.depth_now, got.depth_now);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n;
    logic    token_valid;
    logic    token_ready;
    token_t  token;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    calc_scoreboard sb;
    int unsigned    tokens_taken;
    int unsigned    items_sent;
    int unsigned    cycle_count;
    bit             quiet;
    bit             held_off;

    logic [2:0] arith_ops[4] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV};

    rpn_stack_calculator #(.STACK_DEPTH(CALC_DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .token_valid  (token_valid),
        .token_ready  (token_ready),
        .token        (token),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #4 clk = ~clk;

    // Both channels are sampled at the rising edge, before the block updates them.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
                sb.check_result(result);
            if (token_valid && token_ready)
            begin
                sb.note_token(token);
                tokens_taken++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [WORD_W-1:0] pick_word();
        int whole;
        int part;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1:
            begin
                whole = int'($urandom_range(0, 200)) - 100;
                return (whole <<< FRAC_W) | $urandom_range(0, 65535);
            end
            2:
            begin
                part = $urandom_range(0, 65535);
                return $urandom_range(0, 1) ? -part : part;
            end
            3:
                case ($urandom_range(0, 5))
                    0: return S32_MAX;
                    1: return S32_MIN;
                    2: return 32'h0000_0001;
                    3: return 32'hFFFF_FFFF;
                    4: return 32'h0001_0000;
                    default: return 32'hFFFF_0000;
                endcase
            4: return '0;
            default:
            begin
                part = $urandom & 32'h00FF_FFFF;
                return $urandom_range(0, 1) ? -part : part;
            end
        endcase
    endfunction

    // Offers one token beat, at times after a random gap, and returns at the falling edge after
    // it was taken.
    task automatic offer(input logic [2:0] op, input logic [WORD_W-1:0] operand);
        token_t t;
        t.op = op;
        t.operand = operand;
        quiet = (items_sent >= ITEM_TOTAL - QUIET_ITEMS);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            token_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        token_valid <= 1'b1;
        token <= t;
        @(posedge clk);
        while (!token_ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic issue(input logic [2:0] op, input logic [WORD_W-1:0] operand);
        if ($urandom_range(0, 15) == 0)
            offer(3'($urandom_range(0, 7)), $urandom);
        offer(op, operand);
    endtask

    // Expressions: build to a random depth, at times one push too many, reduce with operators, usually finish.
    task automatic run_expressions();
        int unsigned target;
        while (items_sent < ITEM_TOTAL)
        begin
            target = $urandom_range(1, CALC_DEPTH + 1);
            while (sb.depth < target && sb.depth < CALC_DEPTH && items_sent < ITEM_TOTAL)
                issue(OP_PUSH, pick_word());
            if (target > CALC_DEPTH)
                issue(OP_PUSH, pick_word());
            while (sb.depth > 1 && items_sent < ITEM_TOTAL)
            begin
                if ($urandom_range(0, 4) == 0 && sb.depth < CALC_DEPTH)
                    issue(OP_PUSH, pick_word());
                else
                    issue(arith_ops[$urandom_range(0, 3)], $urandom);
            end
            if ($urandom_range(0, 9) != 0)
                issue(OP_FINISH, $urandom);
        end
    endtask

    // Result side: random stall bursts, one long hold-off, and no stalls at the end.
    initial
    begin
        result_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held_off && tokens_taken >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (quiet)
            begin
                result_ready <= 1'b1;
                @(negedge clk);
            end
            else
            begin
                result_ready <= ($urandom_range(0, 2) != 0);
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
        end
    end

    initial
    begin
        sb = new;
        rst_n = 1'b0;
        token_valid = 1'b0;
        token = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Errors on an empty stack, saturating arithmetic, divide by zero and overflow.
        offer(OP_FINISH, '0);
        offer(OP_ADD, '0);
        offer(OP_BAD_HI, 32'hFFFF_FFFF);
        offer(OP_PUSH, S32_MAX);
        offer(OP_SUB, '0);
        offer(OP_PUSH, S32_MAX);
        offer(OP_ADD, '0);
        offer(OP_PUSH, S32_MIN);
        offer(OP_SUB, '0);
        offer(OP_PUSH, '0);
        offer(OP_DIV, '0);
        offer(OP_BAD_LO, '0);
        offer(OP_PUSH, 32'h0003_8000);
        offer(OP_MUL, '0);
        offer(OP_PUSH, S32_MIN);
        offer(OP_PUSH, 32'hFFFF_FFFF);
        offer(OP_DIV, '0);
        offer(OP_PUSH, 32'hFFFF_0000);
        offer(OP_MUL, '0);
        offer(OP_PUSH, S32_MIN);
        offer(OP_MUL, '0);
        offer(OP_PUSH, 32'hFFFE_8000);
        offer(OP_DIV, '0);
        offer(OP_FINISH, '0);

        run_expressions();
        token_valid <= 1'b0;

        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
